// File: rtl/core/pic_pkg.sv
// shared constants for the image checksum block
// no dependencies; imported by every module of the block
package pic_pkg;

  localparam int WORD_BITS   = 16;
  localparam int BYTE_BITS   = 8;
  localparam int COUNT_BITS  = 2;
  localparam int ADDR_BITS   = 32;
  localparam int SUM_BITS    = 32;
  localparam int RESULT_BITS = 32;

  typedef logic [WORD_BITS-1:0]   word_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [ADDR_BITS-1:0]   addr_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [RESULT_BITS-1:0] result_t;

  // byte count codes on the input
  localparam count_t COUNT_NONE = 2'd0;
  localparam count_t COUNT_ONE  = 2'd1;
  localparam count_t COUNT_TWO  = 2'd2;
  localparam count_t COUNT_WIDE = 2'd3;

endpackage

// File: rtl/core/pic_front.sv
// front end: takes items, tracks byte position, blanks the checksum field bytes
// depends on pic_pkg
module pic_front #(
  parameter int LENGTH_BITS = 32,
  parameter int FIELD_BYTES = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  pic_pkg::addr_t         cfg_offset,
  input  logic                   push,
  input  pic_pkg::word_t         data_word,
  input  pic_pkg::count_t        byte_count,
  input  logic                   last,
  output pic_pkg::word_t         word_masked,
  output logic [LENGTH_BITS-1:0] length
);
  import pic_pkg::*;

  localparam addr_t FIELD_SIZE     = ADDR_BITS'(FIELD_BYTES);
  localparam addr_t FIELD_SIZE_M1  = ADDR_BITS'(FIELD_BYTES - 1);

  addr_t  offset;
  addr_t  position;
  addr_t  position_next;
  addr_t  delta;
  count_t advance;
  logic   lo_keep;
  logic   hi_keep;
  logic   lo_in_field;
  logic   hi_in_field;

  always_comb begin
    unique case (byte_count)
      COUNT_NONE: advance = COUNT_NONE;
      COUNT_ONE:  advance = COUNT_ONE;
      COUNT_TWO:  advance = COUNT_TWO;
      COUNT_WIDE: advance = COUNT_TWO;
      default:    advance = COUNT_NONE;
    endcase
  end

  // distance from field start; the field wraps round the address space
  assign delta       = position - offset;
  assign lo_in_field = delta < FIELD_SIZE;
  assign hi_in_field = (&delta) || (delta < FIELD_SIZE_M1);

  assign lo_keep = (advance != COUNT_NONE) && !lo_in_field;
  assign hi_keep = (advance == COUNT_TWO) && !hi_in_field;

  assign word_masked = {hi_keep ? data_word[WORD_BITS-1:BYTE_BITS] : {BYTE_BITS{1'b0}},
                        lo_keep ? data_word[BYTE_BITS-1:0] : {BYTE_BITS{1'b0}}};

  assign position_next = position + ADDR_BITS'(advance);
  assign length        = position_next[LENGTH_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (cfg_valid) begin
      offset <= cfg_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (push) begin
      position <= last ? '0 : position_next;
    end
  end

endmodule

// File: rtl/core/pic_queue.sv
// short flip-flop queue between front and back ends
// depends on pic_pkg for house conventions only
module pic_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);
  import pic_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] fill;

  assign full      = (fill == FULL_CNT);
  assign not_empty = (fill != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/pic_back.sv
// back end: end-around-carry accumulator, fold stage and output register
// depends on pic_pkg
module pic_back #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  pic_pkg::word_t         q_word,
  input  logic [LENGTH_BITS-1:0] q_length,
  input  logic                   q_last,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output pic_pkg::result_t       checksum
);
  import pic_pkg::*;

  localparam int HALF = SUM_BITS / 2;

  sum_t                   acc;
  logic [SUM_BITS:0]      sum_wide;
  sum_t                   acc_next;
  logic                   fin_valid;
  sum_t                   fin_acc;
  logic [LENGTH_BITS-1:0] fin_length;
  logic                   out_ready;
  logic                   fin_ready;
  logic [HALF:0]          fold_wide;
  logic [HALF-1:0]        fold;

  assign out_ready = !out_valid || !out_stall;
  assign fin_ready = !fin_valid || out_ready;
  // a last item needs the fold stage free
  assign q_pop     = q_valid && (!q_last || fin_ready);

  assign sum_wide = {1'b0, acc} + (SUM_BITS + 1)'(q_word);
  assign acc_next = sum_wide[SUM_BITS-1:0] + SUM_BITS'(sum_wide[SUM_BITS]);

  assign fold_wide = {1'b0, fin_acc[HALF-1:0]} + {1'b0, fin_acc[SUM_BITS-1:HALF]};
  assign fold      = fold_wide[HALF-1:0] + HALF'(fold_wide[HALF]);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (q_pop) begin
      acc <= q_last ? '0 : acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_ready) begin
      fin_valid <= q_pop && q_last;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && q_pop && q_last) begin
      fin_acc    <= acc_next;
      fin_length <= q_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && fin_valid) begin
      checksum <= RESULT_BITS'(fold) + RESULT_BITS'(fin_length);
    end
  end

endmodule

// File: rtl/core/pe_image_checksum.sv
// top level of the executable image checksum block
// depends on pic_pkg, pic_front, pic_queue, pic_back
//
// Streams an image as little-endian 16-bit words (byte_count 1 or 2 per item;
// count 0 adds nothing, count 3 counts as 2) and returns one checksum per
// image on the item marked last: the end-around-carry sum of the words,
// folded to 16 bits, plus the image length in bytes. Bytes inside the
// FIELD_BYTES-wide field at field_offset are taken as zero; field_offset is
// written through cfg_valid/cfg_ready, is always ready, and should only be
// changed between images. One item is taken every cycle while in_stall is low;
// the front end's masking feeds a two-entry queue, and the accumulator takes
// one word per cycle from it unless a last item waits for the fold stage. A
// checksum passes from the queue to the fold stage register, then to the
// output register.
module pe_image_checksum #(
  parameter int LENGTH_BITS = 32,
  parameter int FIELD_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  pic_pkg::addr_t    field_offset,
  input  logic              in_valid,
  output logic              in_stall,
  input  pic_pkg::word_t    data_word,
  input  pic_pkg::count_t   byte_count,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_stall,
  output pic_pkg::result_t  checksum
);
  import pic_pkg::*;

  localparam int QUEUE_DEPTH = 2;
  localparam int ENTRY_BITS  = 1 + LENGTH_BITS + WORD_BITS;

  logic                   push;
  word_t                  word_masked;
  logic [LENGTH_BITS-1:0] length;
  logic                   q_full;
  logic                   q_valid;
  logic                   q_pop;
  logic [ENTRY_BITS-1:0]  q_entry;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;

  pic_front #(
    .LENGTH_BITS (LENGTH_BITS),
    .FIELD_BYTES (FIELD_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_offset  (field_offset),
    .push        (push),
    .data_word   (data_word),
    .byte_count  (byte_count),
    .last        (last),
    .word_masked (word_masked),
    .length      (length)
  );

  pic_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({last, length, word_masked}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_entry)
  );

  pic_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_word    (q_entry[WORD_BITS-1:0]),
    .q_length  (q_entry[WORD_BITS +: LENGTH_BITS]),
    .q_last    (q_entry[ENTRY_BITS-1]),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .checksum  (checksum)
  );

endmodule

// File: test/tb.sv
// testbench for pe_image_checksum: streams images, predicts every checksum
// and compares it with what the block returns; depends on pic_pkg and pe_image_checksum
`timescale 1ns / 1ps

module tb;
  import pic_pkg::*;

  localparam int LEN_BITS   = 32;
  localparam int FIELD_LEN  = 4;
  localparam int RAND_ITEMS = 1600;
  localparam int SETTLE     = 8;      // quiet cycles before an offset write or the end
  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_REPORTS = 20;

  typedef enum logic [1:0] {ENT_ITEM, ENT_CFG, ENT_PAUSE} entry_kind_e;
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_e;

  typedef struct {
    entry_kind_e kind;
    word_t       word;
    count_t      count;
    logic        last;
    addr_t       value;
  } entry_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  addr_t   field_offset = '0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  word_t   data_word = '0;
  count_t  byte_count = COUNT_TWO;
  logic    last = 1'b0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  result_t checksum;

  pe_image_checksum #(
    .LENGTH_BITS(LEN_BITS),
    .FIELD_BYTES(FIELD_LEN)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .field_offset(field_offset),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_word(data_word),
    .byte_count(byte_count),
    .last(last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .checksum(checksum)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  entry_t  stim_q[$];
  result_t checksum_q[$];

  // predictor state
  addr_t       offset_copy = '0;
  logic [31:0] run_sum = '0;
  addr_t       run_pos = '0;

  int errors = 0;
  int n_items = 0;
  int n_cfg = 0;
  int n_sums = 0;
  int n_images = 0;

  function automatic logic in_field(addr_t a);
    addr_t d;
    d = a - offset_copy;
    return d < FIELD_LEN;
  endfunction

  task automatic add_to_checksum(word_t w, count_t c, logic lst);
    count_t      n;
    logic [7:0]  lo, hi;
    logic [32:0] s;
    logic [16:0] f;
    logic [15:0] folded;
    logic [63:0] len;
    n = (c == COUNT_WIDE) ? COUNT_TWO : c;
    lo = w[7:0];
    hi = w[15:8];
    if (n != COUNT_TWO) hi = '0;
    if (n == COUNT_NONE) lo = '0;
    if (n != COUNT_NONE && in_field(run_pos)) lo = '0;
    if (n == COUNT_TWO && in_field(run_pos + 32'd1)) hi = '0;
    s = {1'b0, run_sum} + {17'd0, hi, lo};
    run_sum = s[31:0] + {31'd0, s[32]};
    run_pos = run_pos + {30'd0, n};
    if (lst) begin
      f = {1'b0, run_sum[15:0]} + {1'b0, run_sum[31:16]};
      folded = f[15:0] + {15'd0, f[16]};
      len = {32'd0, run_pos} & ((64'd1 << LEN_BITS) - 64'd1);
      checksum_q.push_back({16'd0, folded} + len[31:0]);
      run_sum = '0;
      run_pos = '0;
    end
  endtask

  // driver: bursts of items with random gaps, pauses and offset writes in between
  int burst_left = 1;
  int gap_left = 0;
  int settle = 0;

  always @(posedge clk) begin : driver
    logic nv, ncv;
    if (rst) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        add_to_checksum(data_word, byte_count, last);
        n_items++;
      end
      if (cfg_valid && cfg_ready) begin
        offset_copy = field_offset;
        n_cfg++;
      end
      nv  = in_valid && in_stall;
      ncv = cfg_valid && !cfg_ready;
      if (!nv && !ncv && stim_q.size() != 0) begin
        if (gap_left != 0) begin
          gap_left--;
        end else begin
          case (stim_q[0].kind)
            ENT_ITEM: begin
              data_word  <= stim_q[0].word;
              byte_count <= stim_q[0].count;
              last       <= stim_q[0].last;
              nv = 1'b1;
              void'(stim_q.pop_front());
              burst_left--;
              if (burst_left <= 0) begin
                if ($urandom_range(0, 3) == 0) begin
                  burst_left = $urandom_range(50, 200);
                  gap_left = 0;
                end else begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = $urandom_range(1, 12);
                end
              end
            end
            ENT_CFG: begin
              field_offset <= stim_q[0].value;
              ncv = 1'b1;
              void'(stim_q.pop_front());
            end
            default: begin
              // wait until every checksum is back and the pipe has gone quiet
              if (checksum_q.size() != 0) begin
                settle = 0;
              end else if (settle < SETTLE) begin
                settle++;
              end else begin
                settle = 0;
                void'(stim_q.pop_front());
              end
            end
          endcase
        end
      end
      in_valid  <= nv;
      cfg_valid <= ncv;
    end
  end

  // monitor: checks each checksum and stalls on a pattern of its own
  stall_mode_e stall_mode = STALL_NONE;
  int          mode_left = 0;

  always @(posedge clk) begin : monitor
    result_t want;
    logic    ns;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (checksum_q.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t: unexpected checksum: expected none, actual %h", $time, checksum);
          errors++;
        end else begin
          want = checksum_q.pop_front();
          n_sums++;
          if (checksum !== want) begin
            if (errors < MAX_REPORTS)
              $display("%0t: checksum mismatch: expected %h, actual %h", $time, want, checksum);
            errors++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  ns = 1'b0;
        STALL_LIGHT: ns = ($urandom_range(0, 3) == 0);
        default:     ns = ($urandom_range(0, 3) != 0);
      endcase
      out_stall <= ns;
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic entry_t item(word_t w, count_t c, logic lst);
    entry_t e;
    e.kind = ENT_ITEM;
    e.word = w;
    e.count = c;
    e.last = lst;
    e.value = '0;
    return e;
  endfunction

  task automatic add_pause();
    entry_t e;
    e = item('0, COUNT_NONE, 1'b0);
    e.kind = ENT_PAUSE;
    stim_q.push_back(e);
  endtask

  task automatic add_cfg(addr_t v);
    entry_t e;
    add_pause();
    e = item('0, COUNT_NONE, 1'b0);
    e.kind = ENT_CFG;
    e.value = v;
    stim_q.push_back(e);
  endtask

  initial begin : stimulus
    int     queued;
    int     len;
    addr_t  off;
    count_t c;
    word_t  w;

    // field at the start of the image, one-byte last item
    add_cfg(32'd0);
    stim_q.push_back(item(16'hffff, COUNT_TWO, 1'b0));
    stim_q.push_back(item(16'hffff, COUNT_TWO, 1'b0));
    stim_q.push_back(item(16'hffff, COUNT_TWO, 1'b0));
    stim_q.push_back(item(16'h1234, COUNT_ONE, 1'b1));
    // odd offset splits the field across words
    add_cfg(32'd3);
    stim_q.push_back(item(16'hffff, COUNT_TWO, 1'b0));
    stim_q.push_back(item(16'hffff, COUNT_TWO, 1'b0));
    stim_q.push_back(item(16'hffff, COUNT_TWO, 1'b0));
    stim_q.push_back(item(16'h00ff, COUNT_TWO, 1'b1));
    // field wraps past the top address round to zero; odd counts mid-image
    add_cfg(32'hffffffff);
    stim_q.push_back(item(16'hffff, COUNT_TWO, 1'b0));
    stim_q.push_back(item(16'habcd, COUNT_WIDE, 1'b0));
    stim_q.push_back(item(16'h5a5a, COUNT_NONE, 1'b0));
    stim_q.push_back(item(16'h8001, COUNT_ONE, 1'b0));
    stim_q.push_back(item(16'hffff, COUNT_TWO, 1'b1));
    // empty image, then an image whose fold comes to ffff with no carry
    add_cfg(32'hfffffffe);
    stim_q.push_back(item(16'h1234, COUNT_NONE, 1'b1));
    stim_q.push_back(item(16'h0000, COUNT_TWO, 1'b0));
    stim_q.push_back(item(16'hffff, COUNT_TWO, 1'b0));
    stim_q.push_back(item(16'hffff, COUNT_TWO, 1'b0));
    stim_q.push_back(item(16'hffff, COUNT_WIDE, 1'b1));
    n_images = 5;

    queued = 0;
    while (queued < RAND_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 5))
          0: off = 32'd0;
          1: off = 32'hffffffff;
          2: off = 32'hffffffff - $urandom_range(1, 3);
          3: off = $urandom_range(0, 40);
          4: off = $urandom;
          default: off = $urandom_range(0, 12);
        endcase
        add_cfg(off);
      end else if ($urandom_range(0, 9) == 0) begin
        add_pause();
      end
      len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 3))
          0: w = 16'hffff;
          1: w = word_t'($urandom_range(0, 255));
          default: w = word_t'($urandom);
        endcase
        if (i == len - 1) begin
          case ($urandom_range(0, 9))
            0: c = COUNT_NONE;
            1: c = COUNT_WIDE;
            2, 3, 4: c = COUNT_ONE;
            default: c = COUNT_TWO;
          endcase
        end else begin
          // mostly full words; the odd short or oversize count as noise
          case ($urandom_range(0, 19))
            0: c = COUNT_NONE;
            1: c = COUNT_ONE;
            2: c = COUNT_WIDE;
            default: c = COUNT_TWO;
          endcase
        end
        stim_q.push_back(item(w, c, i == len - 1));
      end
      queued += len;
      n_images++;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || in_valid || cfg_valid || checksum_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (checksum_q.size() != 0) begin
      $display("%0t: %0d checksums never arrived", $time, checksum_q.size());
      errors++;
    end

    $display("%0d items in %0d images sent, %0d checksums compared", n_items, n_images, n_sums);
    $display("%0d field offset writes, including both ends and wrapping fields", n_cfg);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/pic_pkg.sv
rtl/core/pic_front.sv
rtl/core/pic_queue.sv
rtl/core/pic_back.sv
rtl/core/pe_image_checksum.sv
test/tb.sv
